// ----- hw/rtl/sva_pkg.sv -----
// Shared types and constants for the sample voice allocator and player.
// Used by every module in hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package sva_pkg;

  // Default sizing, used as the defaults of the top level parameters.
  localparam int unsigned VOICE_COUNT_DEF = 8;
  localparam int unsigned STORE_WORDS_DEF = 65536;

  // Field widths that the interface fixes.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W    = SAMPLE_W + 1;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Number of sounds that can be triggered.
  localparam int unsigned SOUND_COUNT = 3;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_TRIGGER = 2'd1,
    MODE_RENDER  = 2'd2
  } mode_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECTS_EN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SND0_BASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SND0_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SND1_BASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SND1_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SND2_BASE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SND2_LEN   = 3'd6;

  // Reset layout of the sample store: three sounds packed back to back.
  localparam logic [SAMPLE_W-1:0] SND0_BASE_RST = 16'd0;
  localparam logic [SAMPLE_W-1:0] SND0_LEN_RST  = SAMPLE_W'(13824 / 2);
  localparam logic [SAMPLE_W-1:0] SND1_BASE_RST = SAMPLE_W'(13824 / 2);
  localparam logic [SAMPLE_W-1:0] SND1_LEN_RST  = SAMPLE_W'(12636 / 2);
  localparam logic [SAMPLE_W-1:0] SND2_BASE_RST = SAMPLE_W'((13824 + 12636) / 2);
  localparam logic [SAMPLE_W-1:0] SND2_LEN_RST  = SAMPLE_W'(82200 / 2);

  typedef struct packed {
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] length;
  } sound_cfg_t;

  typedef struct packed {
    logic                         effects_en;
    sound_cfg_t [SOUND_COUNT-1:0] sound;
  } cfg_t;

  // Per-item result of the voice stage, passed to the store pipeline.
  typedef struct packed {
    logic             left_live;
    logic             right_live;
    logic [SUM_W-1:0] left_sum;
    logic [SUM_W-1:0] right_sum;
    logic             taken;
    logic [SLOT_W-1:0] slot;
  } voice_res_t;

endpackage

// ----- hw/rtl/sample_voice_allocator_player_unit.sv -----
// Sample voice allocator and player, top level.
// done_o pulses once an item has passed the input, stage 1 and stage 2 registers.
// Throughput: one item every cycle; busy stays low, since each item passes once
// through the voice registers, the address fold and one store read per side.
// Reset (rst_ni low, asynchronous) frees every voice and restores the sound table;
// store contents are undefined until loaded. The receiver cannot stall results.
`timescale 1ns / 1ps

module sample_voice_allocator_player_unit #(
  parameter int unsigned VOICE_COUNT = sva_pkg::VOICE_COUNT_DEF,
  parameter int unsigned STORE_WORDS = sva_pkg::STORE_WORDS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Item command channel.
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         mode_i,
  input  logic [1:0]                         pair_i,
  input  logic [1:0]                         sound_id_i,
  input  logic [sva_pkg::SAMPLE_W-1:0]       load_address_i,
  input  logic signed [sva_pkg::SAMPLE_W-1:0] load_value_i,
  // Result strobe and fields.
  output logic                               done_o,
  output logic signed [sva_pkg::SAMPLE_W-1:0] left_sample_o,
  output logic signed [sva_pkg::SAMPLE_W-1:0] right_sample_o,
  output logic                               trigger_taken_o,
  output logic [sva_pkg::SLOT_W-1:0]         granted_slot_o,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sva_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sva_pkg::SAMPLE_W-1:0]       cfg_data_i
);

  localparam int unsigned AW = $clog2(STORE_WORDS);
  localparam int unsigned SW = sva_pkg::SAMPLE_W;
  localparam int unsigned XW = sva_pkg::SUM_W;

  // The pipeline never backs up, so the block takes an item in every cycle.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  sva_pkg::cfg_t      cfg;
  sva_pkg::voice_res_t vres;

  sva_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // Stage 0: input register. The payload carries no reset.
  logic           in_valid_q;
  sva_pkg::mode_e mode_q;
  logic [1:0]     pair_q;
  logic [1:0]     sound_id_q;
  logic [SW-1:0]  load_addr_q;
  logic [SW-1:0]  load_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      mode_q       <= sva_pkg::mode_e'(mode_i);
      pair_q       <= pair_i;
      sound_id_q   <= sound_id_i;
      load_addr_q  <= load_address_i;
      load_value_q <= load_value_i;
    end
  end

  // Stage 1: voice state is read and updated in the same cycle, so the next
  // item always sees the slots as this one leaves them.
  sva_voice_ctrl #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_voice (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_q),
    .mode_i     (mode_q),
    .pair_i     (pair_q),
    .sound_id_i (sound_id_q),
    .cfg_i      (cfg),
    .res_o      (vres)
  );

  // Port A carries the load address on a load and the left voice address on a
  // render; port B always carries the right voice address.
  logic          is_load;
  logic [XW-1:0] sum_a;
  logic [AW-1:0] addr_a, addr_b;

  assign is_load = mode_q == sva_pkg::MODE_LOAD;
  assign sum_a   = is_load ? {1'b0, load_addr_q} : vres.left_sum;

  sva_addr_fold #(
    .STORE_WORDS (STORE_WORDS)
  ) u_fold_a (
    .clk_i  (clk_i),
    .x_i    (sum_a),
    .addr_o (addr_a)
  );

  sva_addr_fold #(
    .STORE_WORDS (STORE_WORDS)
  ) u_fold_b (
    .clk_i  (clk_i),
    .x_i    (vres.right_sum),
    .addr_o (addr_b)
  );

  // Stage 1 side-band registers, aligned with the fold registers.
  logic                      s1_valid_q;
  logic                      s1_write_q;
  logic                      s1_left_live_q;
  logic                      s1_right_live_q;
  logic                      s1_taken_q;
  logic [sva_pkg::SLOT_W-1:0] s1_slot_q;
  logic [SW-1:0]             s1_wdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_write_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_q;
      s1_write_q <= in_valid_q && is_load;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_left_live_q  <= vres.left_live;
    s1_right_live_q <= vres.right_live;
    s1_taken_q      <= vres.taken;
    s1_slot_q       <= vres.slot;
    s1_wdata_q      <= load_value_q;
  end

  // Stage 2: store access. A load writes here; a render issues both reads, and
  // the read data registers inside the store line up with the stage 2 flags.
  logic [SW-1:0] rdata_a, rdata_b;

  sva_store #(
    .STORE_WORDS (STORE_WORDS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (s1_write_q),
    .waddr_i   (addr_a),
    .wdata_i   (s1_wdata_q),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  logic                      s2_valid_q;
  logic                      s2_left_live_q;
  logic                      s2_right_live_q;
  logic                      s2_taken_q;
  logic [sva_pkg::SLOT_W-1:0] s2_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_left_live_q  <= s1_left_live_q;
    s2_right_live_q <= s1_right_live_q;
    s2_taken_q      <= s1_taken_q;
    s2_slot_q       <= s1_slot_q;
  end

  // An idle voice, and every item that is not a render, gives silence.
  assign done_o          = s2_valid_q;
  assign left_sample_o   = s2_left_live_q  ? rdata_a : '0;
  assign right_sample_o  = s2_right_live_q ? rdata_b : '0;
  assign trigger_taken_o = s2_taken_q;
  assign granted_slot_o  = s2_slot_q;

endmodule

// ----- hw/rtl/sva_cfg_regs.sv -----
// Configuration register file: effects enable and the three sound descriptors.
// Depends on sva_pkg.
`timescale 1ns / 1ps

module sva_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [sva_pkg::CFG_IDX_W-1:0]      index_i,
  input  logic [sva_pkg::SAMPLE_W-1:0]       data_i,
  output sva_pkg::cfg_t                      cfg_o
);

  sva_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (index_i)
        sva_pkg::CFG_EFFECTS_EN: cfg_d.effects_en      = data_i[0];
        sva_pkg::CFG_SND0_BASE:  cfg_d.sound[0].base   = data_i;
        sva_pkg::CFG_SND0_LEN:   cfg_d.sound[0].length = data_i;
        sva_pkg::CFG_SND1_BASE:  cfg_d.sound[1].base   = data_i;
        sva_pkg::CFG_SND1_LEN:   cfg_d.sound[1].length = data_i;
        sva_pkg::CFG_SND2_BASE:  cfg_d.sound[2].base   = data_i;
        sva_pkg::CFG_SND2_LEN:   cfg_d.sound[2].length = data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.effects_en      <= 1'b1;
      cfg_q.sound[0].base   <= sva_pkg::SND0_BASE_RST;
      cfg_q.sound[0].length <= sva_pkg::SND0_LEN_RST;
      cfg_q.sound[1].base   <= sva_pkg::SND1_BASE_RST;
      cfg_q.sound[1].length <= sva_pkg::SND1_LEN_RST;
      cfg_q.sound[2].base   <= sva_pkg::SND2_BASE_RST;
      cfg_q.sound[2].length <= sva_pkg::SND2_LEN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/sva_voice_ctrl.sv -----
// Voice slot state: allocation of free slots on trigger and position advance on render.
// Depends on sva_pkg.
`timescale 1ns / 1ps

module sva_voice_ctrl #(
  parameter int unsigned VOICE_COUNT = sva_pkg::VOICE_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  sva_pkg::mode_e       mode_i,
  input  logic [1:0]           pair_i,
  input  logic [1:0]           sound_id_i,
  input  sva_pkg::cfg_t        cfg_i,
  output sva_pkg::voice_res_t  res_o
);

  localparam int unsigned VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned IW = (VW > 3) ? VW : 3;
  localparam int unsigned SW = sva_pkg::SAMPLE_W;
  localparam int unsigned XW = sva_pkg::SUM_W;

  logic [VOICE_COUNT-1:0] active_q, active_d;
  logic [1:0]             sound_q [VOICE_COUNT];
  logic [1:0]             sound_d [VOICE_COUNT];
  logic [SW-1:0]          pos_q   [VOICE_COUNT];
  logic [SW-1:0]          pos_d   [VOICE_COUNT];

  logic [IW-1:0] side_idx    [2];
  logic [VW-1:0] side_vi     [2];
  logic          side_active [2];
  logic          side_bad    [2];
  logic          side_live   [2];
  logic          side_end    [2];
  logic [1:0]    side_snd    [2];
  logic [1:0]    side_sel    [2];
  logic [SW-1:0] side_pos    [2];
  logic [XW-1:0] side_sum    [2];
  logic [XW-1:0] side_next   [2];

  logic          is_render;
  logic          trig_ok;
  logic          found;
  logic [VW-1:0] grant;

  assign is_render = valid_i && (mode_i == sva_pkg::MODE_RENDER);
  assign trig_ok   = valid_i && (mode_i == sva_pkg::MODE_TRIGGER) && cfg_i.effects_en &&
                     (sound_id_i < 2'(sva_pkg::SOUND_COUNT));

  // The even voice of the pair feeds the left side, the odd voice the right side.
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      side_idx[s]    = IW'({pair_i, 1'(s)});
      side_vi[s]     = side_idx[s][VW-1:0];
      side_active[s] = ({1'b0, side_idx[s]} < (IW + 1)'(VOICE_COUNT)) &&
                       active_q[side_vi[s]];
      side_snd[s]    = sound_q[side_vi[s]];
      side_pos[s]    = pos_q[side_vi[s]];
      side_bad[s]    = side_snd[s] >= 2'(sva_pkg::SOUND_COUNT);
      side_sel[s]    = side_bad[s] ? 2'd0 : side_snd[s];
      side_live[s]   = side_active[s] && !side_bad[s];
      side_sum[s]    = {1'b0, cfg_i.sound[side_sel[s]].base} + {1'b0, side_pos[s]};
      side_next[s]   = {1'b0, side_pos[s]} + XW'(1);
      side_end[s]    = side_next[s] >= {1'b0, cfg_i.sound[side_sel[s]].length};
    end
  end

  // Lowest-numbered free slot.
  always_comb begin
    found = 1'b0;
    grant = '0;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      if (!found && !active_q[v]) begin
        found = 1'b1;
        grant = VW'(v);
      end
    end
  end

  always_comb begin
    active_d = active_q;
    sound_d  = sound_q;
    pos_d    = pos_q;
    if (trig_ok && found) begin
      active_d[grant] = 1'b1;
      sound_d[grant]  = sound_id_i;
      pos_d[grant]    = '0;
    end
    for (int s = 0; s < 2; s++) begin
      if (is_render && side_active[s]) begin
        if (side_bad[s]) begin
          active_d[side_vi[s]] = 1'b0;
        end else if (side_end[s]) begin
          active_d[side_vi[s]] = 1'b0;
          pos_d[side_vi[s]]    = '0;
        end else begin
          pos_d[side_vi[s]]    = side_next[s][SW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        sound_q[v] <= '0;
        pos_q[v]   <= '0;
      end
    end else begin
      active_q <= active_d;
      sound_q  <= sound_d;
      pos_q    <= pos_d;
    end
  end

  always_comb begin
    res_o.left_live  = is_render && side_live[0];
    res_o.right_live = is_render && side_live[1];
    res_o.left_sum   = side_sum[0];
    res_o.right_sum  = side_sum[1];
    res_o.taken      = trig_ok && found;
    res_o.slot       = (trig_ok && found) ? sva_pkg::SLOT_W'(grant) : '0;
  end

endmodule

// ----- hw/rtl/sva_addr_fold.sv -----
// Two-stage reduction of a 17-bit address sum modulo the store size.
// Depends on sva_pkg.
`timescale 1ns / 1ps

module sva_addr_fold #(
  parameter int unsigned STORE_WORDS = sva_pkg::STORE_WORDS_DEF
) (
  input  logic                             clk_i,
  input  logic [sva_pkg::SUM_W-1:0]        x_i,
  output logic [$clog2(STORE_WORDS)-1:0]   addr_o
);

  localparam int unsigned XW    = sva_pkg::SUM_W;
  localparam int unsigned AW    = $clog2(STORE_WORDS);
  localparam int unsigned NW    = $clog2(STORE_WORDS + 1);
  localparam int unsigned WW    = XW + NW;
  localparam int unsigned RECIP = (1 << XW) / STORE_WORDS;

  // The quotient estimate is the true quotient or one below it.
  logic [2*XW-1:0] prod;
  logic [XW-1:0]   x_q, q_q;
  logic [WW-1:0]   qn, diff, fold;

  assign prod = x_i * XW'(RECIP);

  always_ff @(posedge clk_i) begin
    x_q <= x_i;
    q_q <= prod[2*XW-1:XW];
  end

  assign qn     = q_q * NW'(STORE_WORDS);
  assign diff   = {{NW{1'b0}}, x_q} - qn;
  assign fold   = (diff >= WW'(STORE_WORDS)) ? diff - WW'(STORE_WORDS) : diff;
  assign addr_o = fold[AW-1:0];

endmodule

// ----- hw/rtl/sva_store.sv -----
// Sample store: one write port and two read ports with registered read data.
// Depends on sva_pkg.
`timescale 1ns / 1ps

module sva_store #(
  parameter int unsigned STORE_WORDS = sva_pkg::STORE_WORDS_DEF
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(STORE_WORDS)-1:0]   waddr_i,
  input  logic [sva_pkg::SAMPLE_W-1:0]     wdata_i,
  input  logic [$clog2(STORE_WORDS)-1:0]   raddr_a_i,
  input  logic [$clog2(STORE_WORDS)-1:0]   raddr_b_i,
  output logic [sva_pkg::SAMPLE_W-1:0]     rdata_a_o,
  output logic [sva_pkg::SAMPLE_W-1:0]     rdata_b_o
);

  logic [sva_pkg::SAMPLE_W-1:0] mem [STORE_WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ----- test/sample_voice_allocator_player_unit_tb.sv -----
// Self-checking testbench for sample_voice_allocator_player_unit.
// Depends on sva_pkg and the unit itself; a scoreboard class predicts every frame,
// grant and load acknowledgement, and plain tasks drive the command and config channels.
`timescale 1ns / 1ps

module sample_voice_allocator_player_unit_tb;

  localparam int unsigned SAMPLE_W    = sva_pkg::SAMPLE_W;
  localparam int unsigned SLOT_W      = sva_pkg::SLOT_W;
  localparam int unsigned CFG_IDX_W   = sva_pkg::CFG_IDX_W;
  localparam int unsigned SOUND_COUNT = sva_pkg::SOUND_COUNT;
  localparam int unsigned STORE_WORDS = sva_pkg::STORE_WORDS_DEF;

  // Pipeline depth allowance for the quiet point between phases.
  localparam int          LATENCY      = 3;
  // Generous ceiling on the whole run, counted by the watchdog.
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int          PHASE_ITEMS  = 115;
  localparam int          VOICES       = sva_pkg::VOICE_COUNT_DEF;
  // Mode 3 has no meaning; the unit must answer it with an all-zero result.
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;

  // One expected result item.
  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                taken;
    logic [SLOT_W-1:0]   slot;
  } frame_t;

  // Tracks the voice slots, the sound table and the sample store, and holds the
  // frames that the unit still owes, oldest first.
  class frame_scoreboard;
    frame_t              owed_q[$];
    bit                  effects_en;
    logic [SAMPLE_W-1:0] snd_base[SOUND_COUNT];
    logic [SAMPLE_W-1:0] snd_len[SOUND_COUNT];
    bit                  voice_on[VOICES];
    logic [1:0]          voice_snd[VOICES];
    logic [SAMPLE_W-1:0] voice_pos[VOICES];
    logic [SAMPLE_W-1:0] store[STORE_WORDS];
    bit                  loaded[STORE_WORDS];
    int                  errors;
    int                  n_items, n_loads, n_frames, n_granted, n_refused, n_ends;

    function new();
      effects_en  = 1'b1;
      snd_base[0] = sva_pkg::SND0_BASE_RST;
      snd_len[0]  = sva_pkg::SND0_LEN_RST;
      snd_base[1] = sva_pkg::SND1_BASE_RST;
      snd_len[1]  = sva_pkg::SND1_LEN_RST;
      snd_base[2] = sva_pkg::SND2_BASE_RST;
      snd_len[2]  = sva_pkg::SND2_LEN_RST;
      for (int v = 0; v < VOICES; v++) begin
        voice_on[v]  = 1'b0;
        voice_snd[v] = '0;
        voice_pos[v] = '0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
      case (idx)
        sva_pkg::CFG_EFFECTS_EN: effects_en  = data[0];
        sva_pkg::CFG_SND0_BASE:  snd_base[0] = data;
        sva_pkg::CFG_SND0_LEN:   snd_len[0]  = data;
        sva_pkg::CFG_SND1_BASE:  snd_base[1] = data;
        sva_pkg::CFG_SND1_LEN:   snd_len[1]  = data;
        sva_pkg::CFG_SND2_BASE:  snd_base[2] = data;
        sva_pkg::CFG_SND2_LEN:   snd_len[2]  = data;
        default: ;
      endcase
    endfunction

    // Tells whether rendering this pair would read a store word nobody has loaded.
    function bit unloaded_read(logic [1:0] pair, output logic [SAMPLE_W-1:0] addr);
      int v;
      addr = '0;
      for (int k = 0; k < 2; k++) begin
        v = 2 * pair + k;
        if (voice_on[v]) begin
          addr = snd_base[voice_snd[v]] + voice_pos[v];
          if (!loaded[addr]) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Plays one sample of a voice and moves it on; the store address wraps at 16 bits.
    function logic [SAMPLE_W-1:0] advance_voice(int v);
      logic [SAMPLE_W-1:0] addr;
      logic [SAMPLE_W:0]   next;
      logic [1:0]          s;
      if (!voice_on[v]) return '0;
      s    = voice_snd[v];
      addr = snd_base[s] + voice_pos[v];
      next = {1'b0, voice_pos[v]} + 1'b1;
      // A voice ends once its position reaches the current length, even when the
      // length was lowered underneath it.
      if (next >= {1'b0, snd_len[s]}) begin
        voice_on[v]  = 1'b0;
        voice_pos[v] = '0;
        n_ends++;
      end else begin
        voice_pos[v] = next[SAMPLE_W-1:0];
      end
      return store[addr];
    endfunction

    function void note_item(logic [1:0] mode, logic [1:0] pair, logic [1:0] sid,
                            logic [SAMPLE_W-1:0] laddr, logic [SAMPLE_W-1:0] lval);
      frame_t f;
      f = '0;
      n_items++;
      case (mode)
        sva_pkg::MODE_LOAD: begin
          store[laddr]  = lval;
          loaded[laddr] = 1'b1;
          n_loads++;
        end
        sva_pkg::MODE_TRIGGER: begin
          if (effects_en && sid < SOUND_COUNT) begin
            for (int v = 0; v < VOICES; v++) begin
              if (!voice_on[v]) begin
                voice_on[v]  = 1'b1;
                voice_snd[v] = sid;
                voice_pos[v] = '0;
                f.taken      = 1'b1;
                f.slot       = SLOT_W'(v);
                break;
              end
            end
          end
          if (f.taken) n_granted++;
          else n_refused++;
        end
        sva_pkg::MODE_RENDER: begin
          f.left  = advance_voice(2 * pair);
          f.right = advance_voice(2 * pair + 1);
          n_frames++;
        end
        default: ;
      endcase
      owed_q.push_back(f);
    endfunction

    function int owed();
      return owed_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_result(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right,
                      logic taken, logic [SLOT_W-1:0] slot);
      frame_t f;
      if (owed_q.size() == 0) begin
        report("result strobe with no item outstanding");
        return;
      end
      f = owed_q.pop_front();
      if (left !== f.left)
        report($sformatf("left_sample %0d, expected %0d", $signed(left), $signed(f.left)));
      if (right !== f.right)
        report($sformatf("right_sample %0d, expected %0d", $signed(right), $signed(f.right)));
      if (taken !== f.taken)
        report($sformatf("trigger_taken %0b, expected %0b", taken, f.taken));
      if (slot !== f.slot)
        report($sformatf("granted_slot %0d, expected %0d", slot, f.slot));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [1:0]           mode_i;
  logic [1:0]           pair_i;
  logic [1:0]           sound_id_i;
  logic [SAMPLE_W-1:0]  load_address_i;
  logic [SAMPLE_W-1:0]  load_value_i;
  logic                 done_o;
  logic [SAMPLE_W-1:0]  left_sample_o;
  logic [SAMPLE_W-1:0]  right_sample_o;
  logic                 trigger_taken_o;
  logic [SLOT_W-1:0]    granted_slot_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [SAMPLE_W-1:0]  cfg_data_i;

  frame_scoreboard sb;
  int unsigned     cycle_count;
  int              settings_run;

  // The sound table that the next setting writes; kept here so that a setting can
  // reuse the bases of the one before it.
  bit                  tbl_en;
  logic [SAMPLE_W-1:0] tbl_base[SOUND_COUNT];
  logic [SAMPLE_W-1:0] tbl_len[SOUND_COUNT];

  sample_voice_allocator_player_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .pair_i          (pair_i),
    .sound_id_i      (sound_id_i),
    .load_address_i  (load_address_i),
    .load_value_i    (load_value_i),
    .done_o          (done_o),
    .left_sample_o   (left_sample_o),
    .right_sample_o  (right_sample_o),
    .trigger_taken_o (trigger_taken_o),
    .granted_slot_o  (granted_slot_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Every result strobe is checked against the oldest owed frame. Outputs are read
  // just after the edge, so they still hold the values of the cycle that ended.
  always @(posedge clk_i) begin
    if (done_o === 1'b1)
      sb.check_result(left_sample_o, right_sample_o, trigger_taken_o, granted_slot_o);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Presents one item from the current edge on and returns at the edge that takes it.
  // Start is left high, so a following item goes out back to back.
  task automatic drive_item(logic [1:0] m, logic [1:0] p, logic [1:0] s,
                            logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] v);
    start          <= 1'b1;
    mode_i         <= m;
    pair_i         <= p;
    sound_id_i     <= s;
    load_address_i <= a;
    load_value_i   <= v;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_item(m, p, s, a, v);
  endtask

  // Sends an item. Before a render, any store word that the pair is about to read
  // and that was never loaded gets a load item of its own, so no render ever sees
  // undefined store contents.
  task automatic send_item(logic [1:0] m, logic [1:0] p, logic [1:0] s,
                           logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] v);
    logic [SAMPLE_W-1:0] hole;
    if (m == sva_pkg::MODE_RENDER) begin
      while (sb.unloaded_read(p, hole))
        drive_item(sva_pkg::MODE_LOAD, 2'($urandom), 2'($urandom), hole,
                   SAMPLE_W'($urandom));
    end
    drive_item(m, p, s, a, v);
  endtask

  // Drops start and holds off until the unit owes nothing more.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.owed() != 0) @(posedge clk_i);
  endtask

  // Quiet point between phases: drained, plus the pipeline depth for good measure.
  task automatic quiesce();
    wait_drained();
    repeat (LATENCY + 1) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic write_sound_table();
    cfg_write(sva_pkg::CFG_EFFECTS_EN, {15'd0, tbl_en});
    cfg_write(sva_pkg::CFG_SND0_BASE, tbl_base[0]);
    cfg_write(sva_pkg::CFG_SND0_LEN, tbl_len[0]);
    cfg_write(sva_pkg::CFG_SND1_BASE, tbl_base[1]);
    cfg_write(sva_pkg::CFG_SND1_LEN, tbl_len[1]);
    cfg_write(sva_pkg::CFG_SND2_BASE, tbl_base[2]);
    cfg_write(sva_pkg::CFG_SND2_LEN, tbl_len[2]);
    settings_run++;
  endtask

  // Settings walk from short sounds that recycle slots quickly, through the store
  // wrap, effects switched off and endless sounds, to lengths cut below running
  // positions and finally fully random tables.
  task automatic choose_setting(int ph);
    for (int s = 0; s < SOUND_COUNT; s++) begin
      tbl_en = 1'b1;
      case (ph)
        1: begin
          tbl_base[s] = SAMPLE_W'($urandom);
          tbl_len[s]  = SAMPLE_W'($urandom_range(1, 4));
        end
        2: begin
          tbl_base[s] = (s == 0) ? 16'h0000 : (s == 1) ? 16'hFFFF : SAMPLE_W'($urandom);
          tbl_len[s]  = 16'd1;
        end
        3, 4: begin
          tbl_en      = (ph == 3);
          tbl_base[s] = 16'hFFFF;
          tbl_len[s]  = SAMPLE_W'($urandom_range(2, 6));
        end
        5: begin
          tbl_base[s] = SAMPLE_W'($urandom);
          tbl_len[s]  = 16'hFFFF;
        end
        6: tbl_len[s] = SAMPLE_W'($urandom_range(1, 3));
        7: begin
          tbl_base[s] = SAMPLE_W'($urandom);
          tbl_len[s]  = SAMPLE_W'($urandom_range(1, 16));
        end
        default: begin
          tbl_base[s] = SAMPLE_W'($urandom);
          tbl_len[s]  = SAMPLE_W'($urandom_range(1, 65535));
        end
      endcase
    end
    write_sound_table();
  endtask

  // Extremes of the load fields, the unused mode, a bad sound id, every sound and
  // pair, all eight slots filled and a trigger refused for want of a free slot.
  task automatic directed_items();
    send_item(sva_pkg::MODE_LOAD, 2'd0, 2'd0, 16'h0000, 16'h8000);
    send_item(sva_pkg::MODE_LOAD, 2'd3, 2'd3, 16'hFFFF, 16'h7FFF);
    send_item(sva_pkg::MODE_LOAD, 2'd1, 2'd1, sva_pkg::SND1_BASE_RST, 16'hFFFF);
    send_item(sva_pkg::MODE_LOAD, 2'd2, 2'd2, sva_pkg::SND2_BASE_RST, 16'h0000);
    send_item(MODE_UNUSED, 2'd3, 2'd3, 16'hFFFF, 16'hFFFF);
    send_item(sva_pkg::MODE_TRIGGER, 2'd0, 2'd3, 16'h0000, 16'h0000);
    send_item(sva_pkg::MODE_TRIGGER, 2'd0, 2'd0, 16'h0000, 16'h0000);
    send_item(sva_pkg::MODE_TRIGGER, 2'd1, 2'd1, 16'h0000, 16'h0000);
    send_item(sva_pkg::MODE_TRIGGER, 2'd2, 2'd2, 16'h0000, 16'h0000);
    send_item(sva_pkg::MODE_RENDER, 2'd0, 2'd0, 16'h0000, 16'h0000);
    send_item(sva_pkg::MODE_RENDER, 2'd1, 2'd0, 16'h0000, 16'h0000);
    for (int k = 0; k < 6; k++)
      send_item(sva_pkg::MODE_TRIGGER, 2'd0, 2'(k % 3), 16'h0000, 16'h0000);
    for (int p = 0; p < 4; p++)
      send_item(sva_pkg::MODE_RENDER, 2'(p), 2'd3, 16'hFFFF, 16'hFFFF);
  endtask

  // Random items: mostly triggers and renders so that slots fill, play out and get
  // reused, with loads everywhere in the store and a sprinkle of bad ids and the
  // unused mode. Every field is randomized whatever the mode.
  task automatic random_items(int count, int idle_pct);
    int         pause_at;
    int         r;
    logic [1:0] m, p, s;
    logic [SAMPLE_W-1:0] a, v;
    pause_at = $urandom_range(10, count - 10);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      p = 2'($urandom);
      s = 2'($urandom);
      a = SAMPLE_W'($urandom);
      v = SAMPLE_W'($urandom);
      if (r < 22) begin
        m = sva_pkg::MODE_LOAD;
      end else if (r < 52) begin
        m = sva_pkg::MODE_TRIGGER;
        if (s == 2'd3 && $urandom_range(9) != 0) s = 2'($urandom_range(0, 2));
      end else if (r < 96) begin
        m = sva_pkg::MODE_RENDER;
      end else begin
        m = MODE_UNUSED;
      end
      send_item(m, p, s, a, v);
      // Now and then the sender stops until every owed result is back.
      if (i == pause_at || $urandom_range(99) == 0) begin
        wait_drained();
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    int idle_pct[4];
    idle_pct[0] = 0;
    idle_pct[1] = 55;
    idle_pct[2] = 0;
    idle_pct[3] = 33;
    sb             = new();
    settings_run   = 1;
    rst_ni         = 1'b0;
    start          = 1'b0;
    mode_i         = '0;
    pair_i         = '0;
    sound_id_i     = '0;
    load_address_i = '0;
    load_value_i   = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The reset sound table first, then the directed items on it.
    directed_items();
    random_items(PHASE_ITEMS, idle_pct[0]);
    quiesce();

    // Voices stay alive across settings, so each table change also acts on
    // sounds that are still playing.
    for (int ph = 1; ph <= 8; ph++) begin
      choose_setting(ph);
      random_items(PHASE_ITEMS, idle_pct[ph % 4]);
      quiesce();
    end

    $display("Covered %0d items over %0d sound tables and several sender idle patterns.",
             sb.n_items, settings_run);
    $display("That was %0d loads, %0d frames, %0d granted and %0d refused triggers,",
             sb.n_loads, sb.n_frames, sb.n_granted, sb.n_refused);
    $display("and %0d voices played to their end.", sb.n_ends);
    if (sb.errors == 0 && sb.owed() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sva_pkg.sv
hw/rtl/sva_cfg_regs.sv
hw/rtl/sva_voice_ctrl.sv
hw/rtl/sva_addr_fold.sv
hw/rtl/sva_store.sv
hw/rtl/sample_voice_allocator_player_unit.sv
test/sample_voice_allocator_player_unit_tb.sv
